// ===== hw/rtl/motor_feedback_frame_decoder_unit_defines.svh =====
// Assertion helpers for the motor feedback frame decoder.
`ifndef MOTOR_FEEDBACK_FRAME_DECODER_UNIT_DEFINES_SVH
`define MOTOR_FEEDBACK_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFD_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MFD_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/mfd_pkg.sv =====
`timescale 1ns / 1ps

package mfd_pkg;

    localparam int LIMIT_W     = 24;   // unsigned Q8.16 half range
    localparam int POS_CODE_W  = 16;
    localparam int VT_CODE_W   = 12;
    localparam int VALUE_W     = 25;   // signed Q8.16
    localparam int TURNS_W     = 16;
    localparam int TOTAL_W     = 41;   // signed Q24.16
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 160;
    localparam int CFG_INDEX_W = 2;

    localparam logic [LIMIT_W-1:0] POSITION_LIMIT_RST = 24'd819200;   // 12.5
    localparam logic [LIMIT_W-1:0] VELOCITY_LIMIT_RST = 24'd2949120;  // 45.0
    localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RST   = 24'd1179648;  // 18.0

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POSITION_LIMIT = 2'd0,
        CFG_VELOCITY_LIMIT = 2'd1,
        CFG_TORQUE_LIMIT   = 2'd2
    } cfg_index_t;

    // Per-stage load strobes of the pipeline
    typedef struct packed {
        logic ld_in;
        logic ld_prod;
        logic ld_scale;
        logic ld_turn;
        logic ld_total;
    } pipe_en_t;

endpackage

// ===== hw/rtl/mfd_scale.sv =====
`timescale 1ns / 1ps

// Maps an unsigned code onto [-limit, +limit]:
//   floor(code * 2 * limit / (2^CODE_W - 1)) - limit
// Stage 1 registers the product, stage 2 divides by the all-ones constant
// using 2^CODE_W == 1 (mod den): fold high part onto low part a few times,
// then one compare-and-correct.
module mfd_scale #(
    parameter int CODE_W = mfd_pkg::POS_CODE_W
) (
    input  logic                                 clk,
    input  mfd_pkg::pipe_en_t                    en,
    input  logic [CODE_W-1:0]                    code,
    input  logic [mfd_pkg::LIMIT_W-1:0]          limit,
    output logic signed [mfd_pkg::VALUE_W-1:0]   value
);

    localparam int PROD_W = CODE_W + mfd_pkg::LIMIT_W;
    localparam int DBL_W  = PROD_W + 1;
    localparam int QUO_W  = mfd_pkg::LIMIT_W + 1;
    // fold count: each fold strips about CODE_W-1 bits
    localparam int NLVL   = (DBL_W + CODE_W - 2) / (CODE_W - 1);
    localparam logic [DBL_W-1:0] DEN = {{(DBL_W-CODE_W){1'b0}}, {CODE_W{1'b1}}};

    logic [PROD_W-1:0]                   prod_reg;
    logic [PROD_W-1:0]                   prod_next;
    logic [DBL_W-1:0]                    rem_sum;
    logic [DBL_W-1:0]                    quo_acc;
    logic [QUO_W-1:0]                    quo;
    logic signed [QUO_W:0]               value_wide;
    logic signed [mfd_pkg::VALUE_W-1:0]  value_reg;
    logic signed [mfd_pkg::VALUE_W-1:0]  value_next;

    assign prod_next = PROD_W'(code) * PROD_W'(limit);

    always_comb
    begin
        rem_sum = {prod_reg, 1'b0};
        quo_acc = '0;
        for (int lvl = 0; lvl < NLVL; lvl++)
        begin
            quo_acc = quo_acc + (rem_sum >> CODE_W);
            rem_sum = (rem_sum >> CODE_W) + (rem_sum & DEN);
        end
        if (rem_sum >= DEN)
        begin
            quo_acc = quo_acc + DBL_W'(1);
        end
    end

    assign quo        = quo_acc[QUO_W-1:0];
    assign value_wide = $signed({1'b0, quo}) - $signed({2'b00, limit});
    assign value_next = value_wide[mfd_pkg::VALUE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en.ld_prod)
        begin
            prod_reg <= prod_next;
        end
        if (en.ld_scale)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== hw/rtl/mfd_wrap.sv =====
`timescale 1ns / 1ps

// Turn tracking and multi-turn position.
// Turn stage: compare the new position against the previous one and step the
// saturating turn counter; the state registers are this stage's output.
// Total stage: position + turns * 2 * limit, saturated to the output width.
module mfd_wrap (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mfd_pkg::pipe_en_t                    en,
    input  logic signed [mfd_pkg::VALUE_W-1:0]   position_in,
    input  logic [mfd_pkg::LIMIT_W-1:0]          limit,
    output logic signed [mfd_pkg::VALUE_W-1:0]   position,
    output logic signed [mfd_pkg::TURNS_W-1:0]   turns,
    output logic signed [mfd_pkg::TOTAL_W-1:0]   total
);

    localparam int VW     = mfd_pkg::VALUE_W;
    localparam int TW     = mfd_pkg::TURNS_W;
    localparam int OW     = mfd_pkg::TOTAL_W;
    localparam int DIFF_W = VW + 2;
    localparam int PROD_W = TW + mfd_pkg::LIMIT_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic signed [TW-1:0]    TURNS_MAX = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0]    TURNS_MIN = {1'b1, {(TW-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] TOTAL_MAX = {{(SUM_W-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] TOTAL_MIN = {{(SUM_W-OW+1){1'b1}}, {(OW-1){1'b0}}};

    logic signed [VW-1:0]     last_position_reg;
    logic signed [VW-1:0]     last_position_next;
    logic signed [TW-1:0]     turn_count_reg;
    logic signed [TW-1:0]     turn_count_next;
    logic signed [VW:0]       diff;
    logic signed [DIFF_W-1:0] diff2;
    logic signed [DIFF_W-1:0] limit_s;
    logic                     jump_up;
    logic                     jump_down;
    logic signed [PROD_W-1:0] wrap_prod;
    logic signed [SUM_W-1:0]  total_sum;
    logic signed [OW-1:0]     total_next;
    logic signed [VW-1:0]     position_reg;
    logic signed [TW-1:0]     turns_reg;
    logic signed [OW-1:0]     total_reg;

    // "more than half the limit" is 2*diff > limit, no rounding
    assign diff      = $signed({position_in[VW-1], position_in})
                     - $signed({last_position_reg[VW-1], last_position_reg});
    assign diff2     = {diff, 1'b0};
    assign limit_s   = $signed({3'b000, limit});
    assign jump_up   = diff2 > limit_s;
    assign jump_down = diff2 < -limit_s;

    always_comb
    begin
        turn_count_next    = turn_count_reg;
        last_position_next = position_in;
        priority if (jump_up)
        begin
            if (turn_count_reg != TURNS_MIN)
            begin
                turn_count_next = turn_count_reg - TW'(1);
            end
        end
        else if (jump_down)
        begin
            if (turn_count_reg != TURNS_MAX)
            begin
                turn_count_next = turn_count_reg + TW'(1);
            end
        end
        else
        begin
            turn_count_next = turn_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_position_reg <= '0;
            turn_count_reg    <= '0;
        end
        else if (en.ld_turn)
        begin
            last_position_reg <= last_position_next;
            turn_count_reg    <= turn_count_next;
        end
    end

    assign wrap_prod = PROD_W'(turn_count_reg) * PROD_W'($signed({1'b0, limit}));
    assign total_sum = $signed({wrap_prod[PROD_W-1], wrap_prod, 1'b0})
                     + $signed({{(SUM_W-VW){last_position_reg[VW-1]}}, last_position_reg});

    always_comb
    begin
        priority if (total_sum > TOTAL_MAX)
        begin
            total_next = TOTAL_MAX[OW-1:0];
        end
        else if (total_sum < TOTAL_MIN)
        begin
            total_next = TOTAL_MIN[OW-1:0];
        end
        else
        begin
            total_next = total_sum[OW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld_total)
        begin
            position_reg <= last_position_reg;
            turns_reg    <= turn_count_reg;
            total_reg    <= total_next;
        end
    end

    assign position = position_reg;
    assign turns    = turns_reg;
    assign total    = total_reg;

endmodule

// ===== hw/rtl/motor_feedback_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// Motor feedback frame decoder.
// Input stream (s_axis_*): one word per 8-byte feedback frame, byte0 in the
// low bits. Output stream (m_axis_*): one decoded word per frame, in order.
// cfg_wr_en/cfg_index/cfg_data write the position, velocity and torque half
// ranges (unsigned Q8.16); write them only while no frame is in flight.
// A word accepted into the input reg passes through multiply, constant divide,
// turn tracking and the total/output reg before it shows up on m_axis_tvalid.
// Throughput: one word per cycle unless the output stalls, set by the five-stage pipe;
// each stage has its own ready, so bubbles collapse and a word is taken whenever any
// stage is free, also while the output word waits on m_axis_tready.
// s_axis_tready drops only when all five stages hold a word and the output
// word is stalled.
// Reset: pipeline empty, limits back to 12.5 / 45.0 / 18.0, last position and
// turn count zero, so the first frame is compared against position zero.
// Turn count saturates at the 16-bit limits; total position saturates at the
// 41-bit limits.
`include "motor_feedback_frame_decoder_unit_defines.svh"

module motor_feedback_frame_decoder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // byte0 [7:0], byte1 [15:8], byte2 [23:16], byte3 [31:24],
    // byte4 [39:32], byte5 [47:40], byte6 [55:48], byte7 [63:56]
    input  logic [mfd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // motor_id [3:0], motor_state [7:4], position [32:8], velocity [57:33],
    // torque [82:58], mos_temperature [90:83], coil_temperature [98:91],
    // turns [114:99], total_position [155:115], zero [159:156]
    output logic [mfd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [mfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mfd_pkg::LIMIT_W-1:0]         cfg_data
);

    localparam int VW       = mfd_pkg::VALUE_W;
    localparam int FIELDS_W = 4 + 4 + 3 * VW + 8 + 8 + mfd_pkg::TURNS_W + mfd_pkg::TOTAL_W;

    // Fields that ride along the pipe untouched
    typedef struct packed {
        logic [3:0] id;
        logic [3:0] state;
        logic [7:0] mos;
        logic [7:0] coil;
    } meta_t;

    // ---------------- configuration ----------------
    logic [mfd_pkg::LIMIT_W-1:0] pos_limit_reg;
    logic [mfd_pkg::LIMIT_W-1:0] pos_limit_next;
    logic [mfd_pkg::LIMIT_W-1:0] vel_limit_reg;
    logic [mfd_pkg::LIMIT_W-1:0] vel_limit_next;
    logic [mfd_pkg::LIMIT_W-1:0] tor_limit_reg;
    logic [mfd_pkg::LIMIT_W-1:0] tor_limit_next;

    always_comb
    begin
        pos_limit_next = pos_limit_reg;
        vel_limit_next = vel_limit_reg;
        tor_limit_next = tor_limit_reg;
        if (cfg_wr_en)
        begin
            unique case (mfd_pkg::cfg_index_t'(cfg_index))
                mfd_pkg::CFG_POSITION_LIMIT: pos_limit_next = cfg_data;
                mfd_pkg::CFG_VELOCITY_LIMIT: vel_limit_next = cfg_data;
                mfd_pkg::CFG_TORQUE_LIMIT:   tor_limit_next = cfg_data;
                default:                     pos_limit_next = pos_limit_reg;  // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_limit_reg <= mfd_pkg::POSITION_LIMIT_RST;
            vel_limit_reg <= mfd_pkg::VELOCITY_LIMIT_RST;
            tor_limit_reg <= mfd_pkg::TORQUE_LIMIT_RST;
        end
        else
        begin
            pos_limit_reg <= pos_limit_next;
            vel_limit_reg <= vel_limit_next;
            tor_limit_reg <= tor_limit_next;
        end
    end

    // ---------------- pipeline control ----------------
    // Stages: in (frame reg), prod, scale, turn, out.
    logic v_in_reg,    v_in_next;
    logic v_prod_reg,  v_prod_next;
    logic v_scale_reg, v_scale_next;
    logic v_turn_reg,  v_turn_next;
    logic v_out_reg,   v_out_next;
    logic rdy_in, rdy_prod, rdy_scale, rdy_turn, rdy_out;
    mfd_pkg::pipe_en_t en;

    // A stage can load when it is empty or its word moves on this cycle
    assign rdy_out   = !v_out_reg   || m_axis_tready;
    assign rdy_turn  = !v_turn_reg  || rdy_out;
    assign rdy_scale = !v_scale_reg || rdy_turn;
    assign rdy_prod  = !v_prod_reg  || rdy_scale;
    assign rdy_in    = !v_in_reg    || rdy_prod;

    assign en.ld_in    = rdy_in    && s_axis_tvalid;
    assign en.ld_prod  = rdy_prod  && v_in_reg;
    assign en.ld_scale = rdy_scale && v_prod_reg;
    assign en.ld_turn  = rdy_turn  && v_scale_reg;   // also steps the turn state
    assign en.ld_total = rdy_out   && v_turn_reg;

    assign v_in_next    = rdy_in    ? s_axis_tvalid : v_in_reg;
    assign v_prod_next  = rdy_prod  ? v_in_reg      : v_prod_reg;
    assign v_scale_next = rdy_scale ? v_prod_reg    : v_scale_reg;
    assign v_turn_next  = rdy_turn  ? v_scale_reg   : v_turn_reg;
    assign v_out_next   = rdy_out   ? v_turn_reg    : v_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg    <= 1'b0;
            v_prod_reg  <= 1'b0;
            v_scale_reg <= 1'b0;
            v_turn_reg  <= 1'b0;
            v_out_reg   <= 1'b0;
        end
        else
        begin
            v_in_reg    <= v_in_next;
            v_prod_reg  <= v_prod_next;
            v_scale_reg <= v_scale_next;
            v_turn_reg  <= v_turn_next;
            v_out_reg   <= v_out_next;
        end
    end

    assign s_axis_tready = rdy_in;
    assign m_axis_tvalid = v_out_reg;

    // ---------------- datapath ----------------
    logic [mfd_pkg::IN_TDATA_W-1:0]       frame_reg;
    logic [mfd_pkg::POS_CODE_W-1:0]       pos_code;
    logic [mfd_pkg::VT_CODE_W-1:0]        vel_code;
    logic [mfd_pkg::VT_CODE_W-1:0]        tor_code;
    meta_t                                meta_in;
    meta_t                                meta_prod_reg;
    meta_t                                meta_scale_reg;
    meta_t                                meta_turn_reg;
    meta_t                                meta_out_reg;
    logic signed [VW-1:0]                 pos_scaled;
    logic signed [VW-1:0]                 vel_scaled;
    logic signed [VW-1:0]                 tor_scaled;
    logic signed [VW-1:0]                 vel_turn_reg;
    logic signed [VW-1:0]                 tor_turn_reg;
    logic signed [VW-1:0]                 vel_out_reg;
    logic signed [VW-1:0]                 tor_out_reg;
    logic signed [VW-1:0]                 pos_out;
    logic signed [mfd_pkg::TURNS_W-1:0]   turns_out;
    logic signed [mfd_pkg::TOTAL_W-1:0]   total_out;

    always_ff @(posedge clk)
    begin
        if (en.ld_in)
        begin
            frame_reg <= s_axis_tdata;
        end
        if (en.ld_prod)
        begin
            meta_prod_reg <= meta_in;
        end
        if (en.ld_scale)
        begin
            meta_scale_reg <= meta_prod_reg;
        end
        if (en.ld_turn)
        begin
            meta_turn_reg <= meta_scale_reg;
            vel_turn_reg  <= vel_scaled;
            tor_turn_reg  <= tor_scaled;
        end
        if (en.ld_total)
        begin
            meta_out_reg <= meta_turn_reg;
            vel_out_reg  <= vel_turn_reg;
            tor_out_reg  <= tor_turn_reg;
        end
    end

    // Frame unpacking: position big-endian 16 bits, velocity and torque
    // share byte4 (velocity low nibble on top, torque high nibble below)
    assign pos_code      = {frame_reg[15:8], frame_reg[23:16]};
    assign vel_code      = {frame_reg[31:24], frame_reg[39:36]};
    assign tor_code      = {frame_reg[35:32], frame_reg[47:40]};
    assign meta_in.id    = frame_reg[3:0];
    assign meta_in.state = frame_reg[7:4];
    assign meta_in.mos   = frame_reg[55:48];
    assign meta_in.coil  = frame_reg[63:56];

    mfd_scale #(
        .CODE_W (mfd_pkg::POS_CODE_W)
    ) u_pos_scale (
        .clk   (clk),
        .en    (en),
        .code  (pos_code),
        .limit (pos_limit_reg),
        .value (pos_scaled)
    );

    mfd_scale #(
        .CODE_W (mfd_pkg::VT_CODE_W)
    ) u_vel_scale (
        .clk   (clk),
        .en    (en),
        .code  (vel_code),
        .limit (vel_limit_reg),
        .value (vel_scaled)
    );

    mfd_scale #(
        .CODE_W (mfd_pkg::VT_CODE_W)
    ) u_tor_scale (
        .clk   (clk),
        .en    (en),
        .code  (tor_code),
        .limit (tor_limit_reg),
        .value (tor_scaled)
    );

    mfd_wrap u_wrap (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .position_in (pos_scaled),
        .limit       (pos_limit_reg),
        .position    (pos_out),
        .turns       (turns_out),
        .total       (total_out)
    );

    assign m_axis_tdata = {
        {(mfd_pkg::OUT_TDATA_W-FIELDS_W){1'b0}},
        total_out,
        turns_out,
        meta_out_reg.coil,
        meta_out_reg.mos,
        tor_out_reg,
        vel_out_reg,
        pos_out,
        meta_out_reg.state,
        meta_out_reg.id
    };

    // ---------------- assertions ----------------
    // Backpressure reaches the input only once every stage is occupied
    `MFD_ASSERT_SAME(a_full_when_stalled, clk, rst_n, !s_axis_tready,
        v_in_reg && v_prod_reg && v_scale_reg && v_turn_reg && v_out_reg,
        "input stalled with a free stage")
    // An accepted word always lands in the frame register
    `MFD_ASSERT_NEXT(a_accept_fills_input, clk, rst_n, s_axis_tvalid && s_axis_tready,
        v_in_reg, "accepted word lost at input stage")
    // A new output word only appears if the turn stage held one
    `MFD_ASSERT_SAME(a_out_from_turn, clk, rst_n, $rose(m_axis_tvalid), $past(v_turn_reg),
        "output valid without a word in the turn stage")

endmodule

// ===== verif/motor_feedback_frame_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module motor_feedback_frame_decoder_unit_tb;

    import mfd_pkg::*;

    localparam int    STALL_LIMIT = 2000;  // cycles with no handshake at all
    localparam longint TOTAL_HI   = (64'sd1 <<< 40) - 1;
    localparam longint TOTAL_LO   = -(64'sd1 <<< 40);

    // One output word, laid out as on m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [3:0]                 pad;
        logic signed [TOTAL_W-1:0]  total_position;
        logic signed [TURNS_W-1:0]  turns;
        logic [7:0]                 coil_temperature;
        logic [7:0]                 mos_temperature;
        logic signed [VALUE_W-1:0]  torque;
        logic signed [VALUE_W-1:0]  velocity;
        logic signed [VALUE_W-1:0]  position;
        logic [3:0]                 motor_state;
        logic [3:0]                 motor_id;
    } reading_t;

    // Decoder model plus queue of decoded readings still owed by the block.
    class feedback_scoreboard;
        logic [LIMIT_W-1:0] pos_limit = POSITION_LIMIT_RST;
        logic [LIMIT_W-1:0] vel_limit = VELOCITY_LIMIT_RST;
        logic [LIMIT_W-1:0] tor_limit = TORQUE_LIMIT_RST;
        longint   prev_pos = 0;
        int       turn_cnt = 0;
        int       mismatches = 0;
        reading_t expected_readings[$];

        function void set_limit(cfg_index_t idx, logic [LIMIT_W-1:0] val);
            case (idx)
                CFG_POSITION_LIMIT: pos_limit = val;
                CFG_VELOCITY_LIMIT: vel_limit = val;
                CFG_TORQUE_LIMIT:   tor_limit = val;
                default: ;
            endcase
        endfunction

        // floor(code * 2 * lim / (2^bits - 1)) - lim
        function longint scale_code(longint unsigned code, longint unsigned lim, int bits);
            longint unsigned den;
            longint unsigned q;
            den = (64'd1 << bits) - 1;
            q   = code * 2 * lim / den;
            return longint'(q) - longint'(lim);
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void note_frame(logic [IN_TDATA_W-1:0] word);
            reading_t       r;
            longint unsigned pcode, vcode, tcode;
            longint         pos, vel, tor, diff2, pmax, total;
            pcode = 64'({word[15:8], word[23:16]});
            vcode = 64'({word[31:24], word[39:36]});
            tcode = 64'({word[35:32], word[47:40]});
            pos   = scale_code(pcode, pos_limit, POS_CODE_W);
            vel   = scale_code(vcode, vel_limit, VT_CODE_W);
            tor   = scale_code(tcode, tor_limit, VT_CODE_W);

            // wrap detect: exact 2*diff vs limit, no rounding of the half range
            pmax  = longint'(pos_limit);
            diff2 = 2 * (pos - prev_pos);
            if (diff2 > pmax && turn_cnt > -32768)
                turn_cnt--;
            if (diff2 < -pmax && turn_cnt < 32767)
                turn_cnt++;
            prev_pos = pos;

            total = pos + longint'(turn_cnt) * 2 * pmax;
            if (total > TOTAL_HI)
                total = TOTAL_HI;
            if (total < TOTAL_LO)
                total = TOTAL_LO;

            r                  = '0;
            r.motor_id         = word[3:0];
            r.motor_state      = word[7:4];
            r.position         = pos[VALUE_W-1:0];
            r.velocity         = vel[VALUE_W-1:0];
            r.torque           = tor[VALUE_W-1:0];
            r.mos_temperature  = word[55:48];
            r.coil_temperature = word[63:56];
            r.turns            = turn_cnt[TURNS_W-1:0];
            r.total_position   = total[TOTAL_W-1:0];
            expected_readings.push_back(r);
        endfunction

        function void compare_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_reading(logic [OUT_TDATA_W-1:0] word);
            reading_t e, a;
            a = word;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected output word: expected none, actual %h",
                         $time, word);
                mismatches++;
                return;
            end
            e = expected_readings.pop_front();
            compare_field("motor_id",         e.motor_id,         a.motor_id);
            compare_field("motor_state",      e.motor_state,      a.motor_state);
            compare_field("position",         e.position,         a.position);
            compare_field("velocity",         e.velocity,         a.velocity);
            compare_field("torque",           e.torque,           a.torque);
            compare_field("mos_temperature",  e.mos_temperature,  a.mos_temperature);
            compare_field("coil_temperature", e.coil_temperature, a.coil_temperature);
            compare_field("turns",            e.turns,            a.turns);
            compare_field("total_position",   e.total_position,   a.total_position);
            compare_field("zero pad",         e.pad,              a.pad);
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [LIMIT_W-1:0]        cfg_data;

    feedback_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;

    motor_feedback_frame_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Builds one feedback frame from its decoded fields; byte0 in the low bits.
    function automatic logic [IN_TDATA_W-1:0] make_frame(
        logic [3:0] id, logic [3:0] st, logic [15:0] pcode, logic [11:0] vcode,
        logic [11:0] tcode, logic [7:0] mos, logic [7:0] coil);
        return {coil, mos, tcode[7:0], vcode[3:0], tcode[11:8], vcode[11:4],
                pcode[7:0], pcode[15:8], st, id};
    endfunction

    // Called at a falling edge, returns at a falling edge. tvalid stays high
    // across back-to-back words, so it is never dropped and raised in one step.
    task automatic send_frame(logic [IN_TDATA_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_frame(word);
        @(negedge clk);
    endtask

    // Hold the input off until every decoded word is back, then let the
    // five-stage pipe settle before anything touches the limits.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_limit(cfg_index_t idx, logic [LIMIT_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_limit(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Output side: random backpressure, changed on the falling edge.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every accepted output word is checked right at the edge it moves.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_reading(m_axis_tdata);
    end

    // Watchdog: only cycles where nothing at all moves are counted.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic [IN_TDATA_W-1:0] word;
        logic [15:0]           walk_code;
        logic [LIMIT_W-1:0]    lim;
        int                    step;

        walk_code     = 16'h8000;
        send_idle_pct = 13;
        recv_idle_pct = 75;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_POSITION_LIMIT;
        cfg_data      = '0;
        sb            = new;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed, reset limits ----
        // first frame sits at +max, so it counts as a wrap against zero
        send_frame(make_frame(4'h0, 4'h0, 16'hFFFF, 12'h000, 12'h000, 8'h00, 8'h00));
        send_frame(make_frame(4'hF, 4'hF, 16'h0000, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF));
        send_frame(make_frame(4'h5, 4'hA, 16'h8000, 12'h800, 12'h7FF, 8'h55, 8'hAA));
        send_frame(make_frame(4'hF, 4'hF, 16'hFFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF));
        send_frame(make_frame(4'h0, 4'h0, 16'h0000, 12'h000, 12'h000, 8'h00, 8'h00));
        send_frame(make_frame(4'hA, 4'h5, 16'h7FFF, 12'h7FF, 12'h800, 8'hAA, 8'h55));
        send_frame(make_frame(4'h3, 4'hC, 16'hC000, 12'h001, 12'hFFE, 8'h01, 8'h80));
        send_frame(make_frame(4'hC, 4'h3, 16'h4000, 12'hFFE, 12'h001, 8'h80, 8'h01));

        // ---- tiny position limit: steps of exactly half the limit must not
        // count, one more LSB must; velocity and torque limits of zero ----
        wait_drain();
        write_limit(CFG_POSITION_LIMIT, 24'd4);
        write_limit(CFG_VELOCITY_LIMIT, 24'd0);
        write_limit(CFG_TORQUE_LIMIT, 24'd0);
        send_frame(make_frame(4'h1, 4'h2, 16'd0,     12'hFFF, 12'hFFF, 8'h10, 8'h20));
        send_frame(make_frame(4'h2, 4'h3, 16'd16384, 12'h000, 12'h000, 8'h11, 8'h21));
        send_frame(make_frame(4'h3, 4'h4, 16'd40960, 12'hABC, 12'h123, 8'h12, 8'h22));
        send_frame(make_frame(4'h4, 4'h5, 16'd24576, 12'h800, 12'h7FF, 8'h13, 8'h23));
        send_frame(make_frame(4'h5, 4'h6, 16'd0,     12'h7FF, 12'h800, 8'h14, 8'h24));

        // ---- widest limits; old last position is kept as is ----
        wait_drain();
        write_limit(CFG_POSITION_LIMIT, 24'hFFFFFF);
        write_limit(CFG_VELOCITY_LIMIT, 24'hFFFFFF);
        write_limit(CFG_TORQUE_LIMIT, 24'hFFFFFF);
        send_frame(make_frame(4'h6, 4'h7, 16'hFFFF, 12'hFFF, 12'h000, 8'hFE, 8'h7F));
        send_frame(make_frame(4'h7, 4'h8, 16'h0000, 12'h000, 12'hFFF, 8'h7F, 8'hFE));
        send_frame(make_frame(4'h8, 4'h9, 16'hFFFF, 12'h555, 12'hAAA, 8'hC3, 8'h3C));
        send_frame(make_frame(4'h9, 4'h1, 16'h8000, 12'hAAA, 12'h555, 8'h3C, 8'hC3));

        // ---- random phases: sender-idle / receiver-stall mix, then swapped,
        // then full rate. Fresh limits each phase, extremes included. ----
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 75 : 0;
            recv_idle_pct = (ph < 2) ? 75 : (ph < 4) ? 13 : 0;
            wait_drain();
            for (int k = 0; k < 3; k++)
            begin
                case ($urandom_range(5))
                    0:       lim = '0;
                    1:       lim = '1;
                    2:       lim = 24'($urandom_range(1, 255));
                    default: lim = 24'($urandom);
                endcase
                write_limit(cfg_index_t'(k), lim);
            end
            repeat (205)
            begin
                // now and then let the pipe run dry mid-stream
                if ($urandom_range(149) == 0)
                    wait_drain();
                word = {$urandom, $urandom};
                // mostly a rotating shaft: small steps, wrapping through
                // the code ends, so the turn count walks both ways
                if ($urandom_range(99) < 60)
                begin
                    step      = int'($urandom_range(24576)) - 12288;
                    walk_code = walk_code + 16'(step);
                    {word[15:8], word[23:16]} = walk_code;
                end
                send_frame(word);
            end
        end

        wait_drain();
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
